// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the RC pulse width decoder RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset masking.
`define RCPWD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication in the same cycle, built on the macro above.
`define RCPWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `RCPWD_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication into the next cycle.
`define RCPWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    `RCPWD_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/rcpwd_pkg.sv =====
// rcpwd_pkg: constants, codes and controller/datapath interface types
// for the RC pulse width decoder. No dependencies.
`timescale 1ns / 1ps

package rcpwd_pkg;

    // Capture timer and width scaling
    localparam int CAPTURE_WIDTH = 16;
    localparam int WIDTH_SHIFT   = 5;
    localparam int SCALED_W      = CAPTURE_WIDTH - WIDTH_SHIFT;
    localparam int OVF_W         = 8;
    localparam int TICK_SHIFT_LO = 8;   // 256 counts per overflow tick
    localparam int TICK_SHIFT_HI = 9;   // 512 counts per overflow tick
    localparam int EXT_W = (CAPTURE_WIDTH > OVF_W + TICK_SHIFT_HI) ?
                           CAPTURE_WIDTH : (OVF_W + TICK_SHIFT_HI);

    // Result value and filter
    localparam int VALUE_W  = 11;
    localparam int CMP_W    = (SCALED_W > VALUE_W) ? SCALED_W : VALUE_W;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam int WEIGHT_W = 4;
    localparam int NUM_W    = VALUE_W + WEIGHT_W;   // blend numerator
    localparam int REM_W    = WEIGHT_W + 1;         // divisor w+1 up to 16
    localparam int CNT_W    = $clog2(NUM_W);

    // Stream widths
    localparam int S_TDATA_W = ((CAPTURE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [WEIGHT_W-1:0] RST_FILTER_WEIGHT = 4'd4;
    localparam logic                RST_OVF_WEIGHT_SEL = 1'b0;
    localparam logic [VALUE_W-1:0]  RST_PULSE_OFFSET  = 11'd280;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FILTER_WEIGHT       = 2'd0,
        CFG_OVERFLOW_WEIGHT_SEL = 2'd1,
        CFG_PULSE_OFFSET        = 2'd2
    } t_cfg_addr;

    // Input item kind (carried on tuser)
    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_EDGE = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUT_TICK,
        ST_OUT_RISE,
        ST_WIDTH,
        ST_NUMER,
        ST_DIV,
        ST_OUT_FALL
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic tick;        // count an overflow tick
        logic rise;        // latch start time, clear overflows
        logic fall;        // latch falling capture
        logic width;       // raw width and one-step move
        logic numer;       // blend numerator, divider start
        logic div_step;    // one restoring divide step
        logic commit;      // store new filtered value
        logic out_load;    // load output register
        logic out_done;
        logic out_reload;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic await_rising;
        logic blend_on;
        logic div_last;
    } t_dp_sts;

endpackage

// ===== hw/rtl/rcpwd_dp.sv =====
// rcpwd_dp: datapath of the RC pulse width decoder: config registers, edge
// state, width computation, serial divider and output register. Uses rcpwd_pkg.
`timescale 1ns / 1ps

module rcpwd_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rcpwd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [rcpwd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic [rcpwd_pkg::CAPTURE_WIDTH-1:0]    i_capture_time,
    input  rcpwd_pkg::t_dp_cmd                     i_cmd,
    output rcpwd_pkg::t_dp_sts                     o_sts,
    output logic [rcpwd_pkg::VALUE_W-1:0]          o_pulse_value,
    output logic                                   o_sample_done,
    output logic                                   o_timeout_reload
);

    // Configuration registers
    logic [rcpwd_pkg::WEIGHT_W-1:0] r_filter_weight;
    logic                           r_ovf_weight_sel;
    logic [rcpwd_pkg::VALUE_W-1:0]  r_pulse_offset;

    // Edge state
    logic                                r_await_rising;
    logic [rcpwd_pkg::CAPTURE_WIDTH-1:0] r_start_time;
    logic [rcpwd_pkg::OVF_W-1:0]         r_ovf_count;
    logic [rcpwd_pkg::VALUE_W-1:0]       r_filtered;

    // Working registers
    logic [rcpwd_pkg::CAPTURE_WIDTH-1:0] r_cap;
    logic [rcpwd_pkg::VALUE_W-1:0]       r_raw;
    logic [rcpwd_pkg::VALUE_W-1:0]       r_cur;
    logic [rcpwd_pkg::NUM_W-1:0]         r_num;
    logic [rcpwd_pkg::REM_W-1:0]         r_rem;
    logic [rcpwd_pkg::CNT_W-1:0]         r_cnt;

    // Output register
    logic [rcpwd_pkg::VALUE_W-1:0] r_out_value;
    logic                          r_out_done;
    logic                          r_out_reload;

    logic [rcpwd_pkg::EXT_W-1:0]         ovf_ext;
    logic [rcpwd_pkg::EXT_W-1:0]         span_ext;
    logic [rcpwd_pkg::CAPTURE_WIDTH-1:0] span;
    logic [rcpwd_pkg::CMP_W-1:0]         scaled;
    logic [rcpwd_pkg::CMP_W-1:0]         offset_ext;
    logic [rcpwd_pkg::CMP_W-1:0]         above;
    logic [rcpwd_pkg::VALUE_W-1:0]       n_raw;
    logic [rcpwd_pkg::VALUE_W-1:0]       n_cur;
    logic [rcpwd_pkg::NUM_W-1:0]         n_num;
    logic [rcpwd_pkg::REM_W-1:0]         rem_sh;
    logic [rcpwd_pkg::REM_W-1:0]         divisor;
    logic                                q_bit;
    logic [rcpwd_pkg::VALUE_W-1:0]       n_filtered;

    // Config writes; an unused index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_weight  <= rcpwd_pkg::RST_FILTER_WEIGHT;
            r_ovf_weight_sel <= rcpwd_pkg::RST_OVF_WEIGHT_SEL;
            r_pulse_offset   <= rcpwd_pkg::RST_PULSE_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rcpwd_pkg::CFG_FILTER_WEIGHT:
                    r_filter_weight <= i_cfg_wdata[rcpwd_pkg::WEIGHT_W-1:0];
                rcpwd_pkg::CFG_OVERFLOW_WEIGHT_SEL:
                    r_ovf_weight_sel <= i_cfg_wdata[0];
                rcpwd_pkg::CFG_PULSE_OFFSET:
                    r_pulse_offset <= i_cfg_wdata[rcpwd_pkg::VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // Span since the rising edge, modulo the capture range
    always_comb begin
        ovf_ext = rcpwd_pkg::EXT_W'(r_ovf_count) << (r_ovf_weight_sel ?
                  rcpwd_pkg::TICK_SHIFT_HI : rcpwd_pkg::TICK_SHIFT_LO);
        span_ext = rcpwd_pkg::EXT_W'(r_cap) - rcpwd_pkg::EXT_W'(r_start_time) + ovf_ext;
        span     = span_ext[rcpwd_pkg::CAPTURE_WIDTH-1:0];
        scaled   = rcpwd_pkg::CMP_W'(span[rcpwd_pkg::CAPTURE_WIDTH-1:rcpwd_pkg::WIDTH_SHIFT]);
        offset_ext = rcpwd_pkg::CMP_W'(r_pulse_offset);
        above    = (scaled < offset_ext) ? '0 : (scaled - offset_ext);
        n_raw    = (above > rcpwd_pkg::CMP_W'(rcpwd_pkg::VALUE_MAX)) ?
                   rcpwd_pkg::VALUE_MAX : above[rcpwd_pkg::VALUE_W-1:0];
    end

    // Stored value moves one step toward the raw width
    always_comb begin
        if (r_filtered < n_raw) begin
            n_cur = r_filtered + 1'b1;
        end else if (r_filtered > n_raw) begin
            n_cur = r_filtered - 1'b1;
        end else begin
            n_cur = r_filtered;
        end
    end

    // Blend numerator cur*w + raw, then restoring divide by w+1
    always_comb begin
        n_num   = rcpwd_pkg::NUM_W'(r_cur) * rcpwd_pkg::NUM_W'(r_filter_weight)
                + rcpwd_pkg::NUM_W'(r_raw);
        divisor = rcpwd_pkg::REM_W'(r_filter_weight) + 1'b1;
        rem_sh  = {r_rem[rcpwd_pkg::REM_W-2:0], r_num[rcpwd_pkg::NUM_W-1]};
        q_bit   = (rem_sh >= divisor);
    end

    // Quotient fits in the value width once all numerator bits are shifted
    assign n_filtered = o_sts.blend_on ? r_num[rcpwd_pkg::VALUE_W-1:0] : r_raw;

    // Edge state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await_rising <= 1'b1;
            r_start_time   <= '0;
            r_ovf_count    <= '0;
            r_filtered     <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_ovf_count <= r_ovf_count + 1'b1;
            end
            if (i_cmd.rise) begin
                r_ovf_count    <= '0;
                r_start_time   <= i_capture_time;
                r_await_rising <= 1'b0;
            end
            if (i_cmd.fall) begin
                r_await_rising <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_filtered <= n_filtered;
            end
        end
    end

    // Working registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.fall) begin
            r_cap <= i_capture_time;
        end
        if (i_cmd.width) begin
            r_raw <= n_raw;
            r_cur <= n_cur;
        end
        if (i_cmd.numer) begin
            r_num <= n_num;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[rcpwd_pkg::NUM_W-2:0], q_bit};
            r_rem <= q_bit ? (rem_sh - divisor) : rem_sh;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= i_cmd.commit ? n_filtered : r_filtered;
            r_out_done   <= i_cmd.out_done;
            r_out_reload <= i_cmd.out_reload;
        end
    end

    assign o_sts.await_rising = r_await_rising;
    assign o_sts.blend_on     = (r_filter_weight != '0);
    assign o_sts.div_last     = (r_cnt == rcpwd_pkg::CNT_W'(rcpwd_pkg::NUM_W - 1));

    assign o_pulse_value    = r_out_value;
    assign o_sample_done    = r_out_done;
    assign o_timeout_reload = r_out_reload;

endmodule

// ===== hw/rtl/rcpwd_ctrl.sv =====
// rcpwd_ctrl: sequencing state machine and output valid tracking for the
// RC pulse width decoder. Uses rcpwd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcpwd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  rcpwd_pkg::t_dp_sts i_sts,
    output rcpwd_pkg::t_dp_cmd o_cmd
);

    rcpwd_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer;
    logic              slot_free;

    assign in_xfer   = i_in_valid && (r_state == rcpwd_pkg::ST_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcpwd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_mode == rcpwd_pkg::MODE_TICK) begin
                        n_state = rcpwd_pkg::ST_OUT_TICK;
                    end else if (i_sts.await_rising) begin
                        n_state = rcpwd_pkg::ST_OUT_RISE;
                    end else begin
                        n_state = rcpwd_pkg::ST_WIDTH;
                    end
                end
            end
            rcpwd_pkg::ST_WIDTH: begin
                n_state = i_sts.blend_on ? rcpwd_pkg::ST_NUMER : rcpwd_pkg::ST_OUT_FALL;
            end
            rcpwd_pkg::ST_NUMER: begin
                n_state = rcpwd_pkg::ST_DIV;
            end
            rcpwd_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = rcpwd_pkg::ST_OUT_FALL;
                end
            end
            rcpwd_pkg::ST_OUT_TICK,
            rcpwd_pkg::ST_OUT_RISE,
            rcpwd_pkg::ST_OUT_FALL: begin
                if (slot_free) begin
                    n_state = rcpwd_pkg::ST_IDLE;
                end
            end
            default: n_state = rcpwd_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            rcpwd_pkg::ST_IDLE: begin
                o_cmd.tick = in_xfer && (i_in_mode == rcpwd_pkg::MODE_TICK);
                o_cmd.rise = in_xfer && (i_in_mode == rcpwd_pkg::MODE_EDGE)
                             && i_sts.await_rising;
                o_cmd.fall = in_xfer && (i_in_mode == rcpwd_pkg::MODE_EDGE)
                             && !i_sts.await_rising;
            end
            rcpwd_pkg::ST_WIDTH:    o_cmd.width    = 1'b1;
            rcpwd_pkg::ST_NUMER:    o_cmd.numer    = 1'b1;
            rcpwd_pkg::ST_DIV:      o_cmd.div_step = 1'b1;
            rcpwd_pkg::ST_OUT_TICK: o_cmd.out_load = slot_free;
            rcpwd_pkg::ST_OUT_RISE: begin
                o_cmd.out_load   = slot_free;
                o_cmd.out_reload = 1'b1;
            end
            rcpwd_pkg::ST_OUT_FALL: begin
                o_cmd.out_load = slot_free;
                o_cmd.commit   = slot_free;
                o_cmd.out_done = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    // Output slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcpwd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == rcpwd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Assertions
    `RCPWD_ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_in_ready,
        "input accepted but block still ready next cycle")
    `RCPWD_ASSERT_IMP(a_load_slot_free, i_clk, i_rst_n, o_cmd.out_load,
        !r_out_valid || i_out_ready, "result loaded over an untaken result")
    `RCPWD_ASSERT_IMP(a_commit_with_load, i_clk, i_rst_n, o_cmd.commit,
        o_cmd.out_load && o_cmd.out_done, "filtered value stored without a result")
    `RCPWD_ASSERT_NXT(a_div_start, i_clk, i_rst_n, o_cmd.numer,
        r_state == rcpwd_pkg::ST_DIV, "divider not started after numerator")

endmodule

// ===== hw/rtl/rc_pulse_width_decoder.sv =====
// rc_pulse_width_decoder: top level of the RC servo pulse width decoder.
// Instantiates rcpwd_ctrl and rcpwd_dp; uses rcpwd_pkg.
//
// Usage:
//   Slave stream: one transfer per timer event. tuser = mode (0 overflow tick,
//   1 capture edge), tdata = capture time. Edges alternate rising/falling,
//   starting with rising after reset.
//   Master stream: exactly one result transfer per input transfer.
//   tdata = filtered pulse value, tuser = {timeout_reload, sample_done}.
//   Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
//   (0 filter weight, 1 overflow weight select, 2 pulse offset); write only
//   while idle. Unused index 3 is ignored.
// Sequence: ticks and rising edges go from idle to the output state; falling
//   edges pass the width state and, with the blend on, the numerator state and
//   the bit-serial divide by w+1 (15 steps) first. Input is taken only in idle.
// Reset: synchronous, active low; config returns to w=4, 256-count ticks,
//   offset 280; filtered value and overflow count clear, rising edge expected.
// Backpressure: the result sits in an output register; one more input is
//   accepted and processed while it waits, then the block holds until taken.
`timescale 1ns / 1ps

module rc_pulse_width_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [rcpwd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rcpwd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [rcpwd_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,  // [15:0] capture_time
    input  logic                                 i_s_axis_tuser,  // [0] mode
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [rcpwd_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // [10:0] pulse_value, zero pad
    output logic [rcpwd_pkg::M_TUSER_W-1:0]      o_m_axis_tuser   // [0] sample_done,
                                                                   // [1] timeout_reload
);

    rcpwd_pkg::t_dp_cmd             cmd;
    rcpwd_pkg::t_dp_sts             sts;
    logic [rcpwd_pkg::VALUE_W-1:0]  pulse_value;
    logic                           sample_done;
    logic                           timeout_reload;

    rcpwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_mode   (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rcpwd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_capture_time   (i_s_axis_tdata[rcpwd_pkg::CAPTURE_WIDTH-1:0]),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_pulse_value    (pulse_value),
        .o_sample_done    (sample_done),
        .o_timeout_reload (timeout_reload)
    );

    // Pack result fields
    assign o_m_axis_tdata = rcpwd_pkg::M_TDATA_W'(pulse_value);
    assign o_m_axis_tuser = {timeout_reload, sample_done};

endmodule

// ===== test/rc_pulse_width_decoder_tb.sv =====
// rc_pulse_width_decoder_tb: self-checking testbench for the RC pulse width decoder.
// Drives capture and overflow events through the input stream, predicts every
// result in a scoreboard class; depends on rcpwd_pkg and rc_pulse_width_decoder.
`timescale 1ns / 1ps

module rc_pulse_width_decoder_tb;
    import rcpwd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 30;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               done;
        logic               reload;
    } pulse_result_t;

    // Scoreboard: own copy of decoder state and registers, queue of pending results
    class pulse_scoreboard;
        logic [WEIGHT_W-1:0] weight;
        logic                tick_sel;
        logic [VALUE_W-1:0]  offset;
        logic                awaiting_rise;
        logic [15:0]         start_time;
        logic [OVF_W-1:0]    ovf_count;
        logic [VALUE_W-1:0]  filtered;
        pulse_result_t       expected_pulses[$];
        int unsigned         errors;

        function new();
            weight        = RST_FILTER_WEIGHT;
            tick_sel      = RST_OVF_WEIGHT_SEL;
            offset        = RST_PULSE_OFFSET;
            awaiting_rise = 1'b1;
            start_time    = '0;
            ovf_count     = '0;
            filtered      = '0;
            errors        = 0;
        endfunction

        function void write_reg(t_cfg_addr addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_FILTER_WEIGHT:       weight   = data[WEIGHT_W-1:0];
                CFG_OVERFLOW_WEIGHT_SEL: tick_sel = data[0];
                CFG_PULSE_OFFSET:        offset   = data[VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        // Width from start to capture, scaled, offset removed, stepped and blended
        function logic [VALUE_W-1:0] settle_width(logic [15:0] capture);
            int unsigned tick_counts;
            int unsigned span;
            int unsigned raw;
            int unsigned cur;
            tick_counts = tick_sel ? 512 : 256;
            span = (capture - start_time + ovf_count * tick_counts) & 32'hFFFF;
            raw  = span >> WIDTH_SHIFT;
            cur  = filtered;
            if (raw < offset)
                raw = offset;
            raw = raw - offset;
            if (raw > 2047)
                raw = 2047;
            if (cur < raw)
                cur = cur + 1;
            else if (cur > raw)
                cur = cur - 1;
            if (weight != 0)
                raw = (cur * weight + raw) / (weight + 1);
            return raw[VALUE_W-1:0];
        endfunction

        function void note_transfer(t_mode mode, logic [15:0] capture);
            pulse_result_t res;
            res.done   = 1'b0;
            res.reload = 1'b0;
            if (mode == MODE_TICK) begin
                ovf_count = ovf_count + 1'b1;
            end else if (awaiting_rise) begin
                ovf_count     = '0;
                start_time    = capture;
                awaiting_rise = 1'b0;
                res.reload    = 1'b1;
            end else begin
                awaiting_rise = 1'b1;
                filtered      = settle_width(capture);
                res.done      = 1'b1;
            end
            res.value = filtered;
            expected_pulses.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            pulse_result_t exp_res;
            logic [M_TDATA_W-1:0] exp_data;
            if (expected_pulses.size() == 0) begin
                $display("%0t: unexpected result transfer, tdata %0d tuser %0d",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            exp_res  = expected_pulses.pop_front();
            exp_data = M_TDATA_W'(exp_res.value);
            if (tdata !== exp_data) begin
                $display("%0t: pulse_value expected %0d actual %0d", $time, exp_data, tdata);
                errors++;
            end
            if (tuser[0] !== exp_res.done) begin
                $display("%0t: sample_done expected %0d actual %0d",
                         $time, exp_res.done, tuser[0]);
                errors++;
            end
            if (tuser[1] !== exp_res.reload) begin
                $display("%0t: timeout_reload expected %0d actual %0d",
                         $time, exp_res.reload, tuser[1]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pulses.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tready    = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    bit              quiet = 1'b0;
    int unsigned     idle_cycles = 0;
    pulse_scoreboard sb = new();

    rc_pulse_width_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle gap length: mostly none or short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // One input transfer, with a random gap ahead of it
    task automatic send_item(t_mode mode, logic [15:0] capture);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= capture;
        do @(posedge i_clk); while (!s_tready);
        sb.note_transfer(mode, capture);
    endtask

    // Hold the sender until every pending result is out, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(int unsigned w, int unsigned sel, int unsigned off);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FILTER_WEIGHT;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge i_clk);
        sb.write_reg(CFG_FILTER_WEIGHT, CFG_DATA_W'(w));
        cfg_addr  <= CFG_OVERFLOW_WEIGHT_SEL;
        cfg_wdata <= CFG_DATA_W'(sel);
        @(posedge i_clk);
        sb.write_reg(CFG_OVERFLOW_WEIGHT_SEL, CFG_DATA_W'(sel));
        cfg_addr  <= CFG_PULSE_OFFSET;
        cfg_wdata <= CFG_DATA_W'(off);
        @(posedge i_clk);
        sb.write_reg(CFG_PULSE_OFFSET, CFG_DATA_W'(off));
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed rise/ticks/fall pulses with random content, some noise
    task automatic run_random(int unsigned n);
        int unsigned sent;
        int unsigned ticks;
        int unsigned span;
        int unsigned total;
        int unsigned r;
        int unsigned i;
        logic [15:0] start;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n) begin
            quiet = (sent < 40);
            if (!paused && sent >= n / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 12 || !sb.awaiting_rise) begin
                send_item(t_mode'($urandom_range(0, 1)), 16'($urandom));
                sent++;
            end else begin
                start = 16'($urandom);
                send_item(MODE_EDGE, start);
                sent++;
                r = $urandom_range(0, 149);
                if (r == 0)
                    ticks = $urandom_range(256, 270);   // overflow counter wraps
                else if (r < 100)
                    ticks = 0;
                else if (r < 130)
                    ticks = $urandom_range(1, 3);
                else
                    ticks = $urandom_range(4, 20);
                for (i = 0; i < ticks; i++) begin
                    send_item(MODE_TICK, 16'($urandom));
                    sent++;
                end
                r = $urandom_range(0, 9);
                if (r < 5)
                    span = (sb.offset + $urandom_range(0, 1100)) * 32 + $urandom_range(0, 31);
                else if (r < 7)
                    span = sb.offset * 32 - $urandom_range(0, 300);   // at or below offset
                else
                    span = $urandom;
                total = start + span - (ticks & 255) * (sb.tick_sel ? 512 : 256);
                send_item(MODE_EDGE, total[15:0]);
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    task automatic run_phase(int unsigned w, int unsigned sel, int unsigned off, int unsigned n);
        wait_idle();
        write_config(w, sel, off);
        run_random(n);
    endtask

    // Result side: check every transfer, stall at random
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    // Watchdog: too long without any transfer on either stream
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL rc_pulse_width_decoder");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset configuration: tick before any rise, widest span,
        // wrapped span, overflow ticks in a pulse, width exactly at the offset
        send_item(MODE_TICK, 16'h0000);
        send_item(MODE_EDGE, 16'h0000);
        send_item(MODE_EDGE, 16'hFFFF);
        send_item(MODE_EDGE, 16'hFFFF);
        send_item(MODE_EDGE, 16'h0000);
        send_item(MODE_EDGE, 16'd1000);
        send_item(MODE_TICK, 16'hFFFF);
        send_item(MODE_TICK, 16'h5555);
        send_item(MODE_TICK, 16'hAAAA);
        send_item(MODE_EDGE, 16'(1000 + (280 + 300) * 32 - 3 * 256));
        send_item(MODE_EDGE, 16'h8000);
        send_item(MODE_EDGE, 16'(16'h8000 + 280 * 32));
        send_item(MODE_EDGE, 16'h5555);
        send_item(MODE_EDGE, 16'hAAAA);
        send_item(MODE_TICK, 16'h0001);

        // Blend off, 512-count ticks, zero offset
        wait_idle();
        write_config(0, 1, 0);
        send_item(MODE_EDGE, 16'h0000);
        send_item(MODE_TICK, 16'h0000);
        send_item(MODE_TICK, 16'h0000);
        send_item(MODE_EDGE, 16'hFFFF);
        send_item(MODE_EDGE, 16'h1234);
        send_item(MODE_EDGE, 16'h1234);
        run_random(300);

        run_phase(15, 0, 2047, 250);
        run_phase(15, 1, 280, 300);
        run_phase(1, 0, 1000, 300);
        run_phase($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1100), 300);
        run_phase(4, 0, 280, 400);

        wait_idle();
        if (sb.errors == 0)
            $display("PASS rc_pulse_width_decoder");
        else
            $display("FAIL rc_pulse_width_decoder");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rcpwd_pkg.sv
hw/rtl/rcpwd_dp.sv
hw/rtl/rcpwd_ctrl.sv
hw/rtl/rc_pulse_width_decoder.sv
test/rc_pulse_width_decoder_tb.sv
